/* hdl/cssx_pkg.sv */
package cssx_pkg;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    localparam logic [2:0] KEY_LEAD  = 3'd0;
    localparam logic [2:0] KEY_DONE  = 3'd5;
    localparam logic [2:0] KEY_TRAIL = 3'd6;
    localparam logic [3:0] MAX_DIGITS = 4'd8;

    typedef enum logic [1:0] {
        VS_LEAD   = 2'd0,
        VS_DIGITS = 2'd1,
        VS_TRAIL  = 2'd2,
        VS_BAD    = 2'd3
    } t_vstate;

    typedef struct packed {
        t_vstate     vs;
        logic [31:0] nib;
        logic [3:0]  cnt;
    } t_value;

    typedef struct packed {
        logic        ok;
        logic [31:0] rgba;
    } t_color;

    typedef struct packed {
        logic       color_found;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_result;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a);
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            t = c - 8'h30;
            return {1'b1, t[3:0]};
        end
        if (c >= 8'h61 && c <= 8'h66) begin
            t = c - 8'h57;
            return {1'b1, t[3:0]};
        end
        if (c >= 8'h41 && c <= 8'h46) begin
            t = c - 8'h37;
            return {1'b1, t[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic logic [7:0] key_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h63;
            3'd1:    c = 8'h6f;
            3'd2:    c = 8'h6c;
            3'd3:    c = 8'h6f;
            3'd4:    c = 8'h72;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* hdl/cssx_in_if.sv */
interface cssx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source(output valid, output ch, output last, input ready);
    modport sink(input valid, input ch, input last, output ready);
endinterface

/* hdl/cssx_out_if.sv */
interface cssx_out_if;
    logic       valid;
    logic       ready;
    logic       color_found;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;

    modport source(output valid, output color_found, output red, output green,
                   output blue, output alpha, input ready);
    modport sink(input valid, input color_found, input red, input green,
                 input blue, input alpha, output ready);
endinterface

/* hdl/cssx_color_decode.sv */
module cssx_color_decode (
    input  cssx_pkg::t_value i_val,
    output cssx_pkg::t_color o_color
);

    logic        w_open;
    logic [31:0] b;

    assign b      = i_val.nib;
    assign w_open = (i_val.vs == cssx_pkg::VS_DIGITS) || (i_val.vs == cssx_pkg::VS_TRAIL);

    always_comb begin
        o_color.ok   = 1'b0;
        o_color.rgba = '0;
        unique case (i_val.cnt)
            4'd3: begin
                o_color.ok   = w_open;
                o_color.rgba = {b[11:8], b[11:8], b[7:4], b[7:4], b[3:0], b[3:0],
                                cssx_pkg::ALPHA_OPAQUE};
            end
            4'd4: begin
                o_color.ok   = w_open;
                o_color.rgba = {b[15:12], b[15:12], b[11:8], b[11:8],
                                b[7:4], b[7:4], b[3:0], b[3:0]};
            end
            4'd6: begin
                o_color.ok   = w_open;
                o_color.rgba = {b[23:0], cssx_pkg::ALPHA_OPAQUE};
            end
            4'd8: begin
                o_color.ok   = w_open;
                o_color.rgba = b;
            end
            default: begin
                o_color.ok   = 1'b0;
                o_color.rgba = '0;
            end
        endcase
    end

endmodule

/* hdl/cssx_parser.sv */
module cssx_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_ch,
    input  logic              i_last,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    output cssx_pkg::t_result o_res
);

    typedef enum logic [1:0] {
        PH_KEY   = 2'd0,
        PH_VALUE = 2'd1,
        PH_SKIP  = 2'd2
    } t_phase;

    logic             r_mode;
    logic             r_found;
    logic [31:0]      r_saved;
    t_phase           r_phase;
    logic [2:0]       r_key;
    cssx_pkg::t_value r_val;

    t_phase           n_phase;
    logic [2:0]       n_key;
    cssx_pkg::t_value n_val;

    logic             w_sep;
    logic             w_space;
    logic [4:0]       w_hex;
    logic             w_finish;
    logic             w_hit;
    logic             w_found;
    logic [31:0]      w_color;
    cssx_pkg::t_color w_dec;

    assign w_sep   = r_mode && (i_ch == cssx_pkg::CH_SEMI);
    assign w_space = cssx_pkg::is_space(i_ch);
    assign w_hex   = cssx_pkg::hex_val(i_ch);

    always_comb begin
        n_phase = r_phase;
        n_key   = r_key;
        n_val   = r_val;
        if (!w_sep) begin
            unique case (r_phase)
                PH_VALUE: begin
                    if (r_val.vs != cssx_pkg::VS_BAD) begin
                        if (w_space) begin
                            if (r_val.vs == cssx_pkg::VS_DIGITS) begin
                                n_val.vs = cssx_pkg::VS_TRAIL;
                            end
                        end else if (r_val.vs == cssx_pkg::VS_LEAD &&
                                     i_ch == cssx_pkg::CH_HASH) begin
                            n_val.vs = cssx_pkg::VS_DIGITS;
                        end else if (r_val.vs == cssx_pkg::VS_DIGITS && w_hex[4] &&
                                     r_val.cnt < cssx_pkg::MAX_DIGITS) begin
                            n_val.nib = {r_val.nib[27:0], w_hex[3:0]};
                            n_val.cnt = r_val.cnt + 4'd1;
                        end else begin
                            n_val.vs = cssx_pkg::VS_BAD;
                        end
                    end
                end
                PH_KEY: begin
                    if (i_ch == cssx_pkg::CH_COLON) begin
                        if (r_key == cssx_pkg::KEY_DONE || r_key == cssx_pkg::KEY_TRAIL) begin
                            n_phase = PH_VALUE;
                            n_val   = '{vs: cssx_pkg::VS_LEAD, nib: '0, cnt: '0};
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end else if (w_space) begin
                        if (r_key == cssx_pkg::KEY_DONE) begin
                            n_key = cssx_pkg::KEY_TRAIL;
                        end else if (r_key != cssx_pkg::KEY_LEAD &&
                                     r_key != cssx_pkg::KEY_TRAIL) begin
                            n_phase = PH_SKIP;
                        end
                    end else if (r_key < cssx_pkg::KEY_DONE &&
                                 i_ch == cssx_pkg::key_char(r_key)) begin
                        n_key = r_key + 3'd1;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    cssx_color_decode u_decode (
        .i_val   (n_val),
        .o_color (w_dec)
    );

    assign w_finish = !r_found && (w_sep ? (r_phase == PH_VALUE)
                                         : (i_last && n_phase == PH_VALUE));
    assign w_hit    = w_finish && w_dec.ok;
    assign w_found  = r_found || w_hit;
    assign w_color  = w_hit ? w_dec.rgba : r_saved;

    assign o_res.color_found = w_found;
    assign o_res.red         = w_found ? w_color[31:24] : 8'h00;
    assign o_res.green       = w_found ? w_color[23:16] : 8'h00;
    assign o_res.blue        = w_found ? w_color[15:8]  : 8'h00;
    assign o_res.alpha       = w_found ? w_color[7:0]   : 8'h00;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en || (i_step && i_last)) begin
            if (!i_rst_n) begin
                r_mode <= 1'b0;
            end else if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            r_found <= 1'b0;
            r_saved <= '0;
            r_key   <= cssx_pkg::KEY_LEAD;
            r_val   <= '{vs: cssx_pkg::VS_LEAD, nib: '0, cnt: '0};
            if (!i_rst_n) begin
                r_phase <= PH_VALUE;
            end else if (i_cfg_wr_en) begin
                r_phase <= i_cfg_wr_data ? PH_KEY : PH_VALUE;
            end else begin
                r_phase <= r_mode ? PH_KEY : PH_VALUE;
            end
        end else if (i_step && !r_found) begin
            if (w_sep) begin
                r_found <= w_hit;
                r_saved <= w_color;
                r_phase <= PH_KEY;
                r_key   <= cssx_pkg::KEY_LEAD;
                r_val   <= '{vs: cssx_pkg::VS_LEAD, nib: '0, cnt: '0};
            end else begin
                r_phase <= n_phase;
                r_key   <= n_key;
                r_val   <= n_val;
            end
        end
    end

endmodule

/* hdl/css_hex_color_extractor.sv */
// Result path: an accepted last byte is held in the input register, and its result word is then registered for o_color.
// Throughput: one byte per cycle; a last byte waits in the input register only
// while a result word is held and not drained.
// Reset (i_rst_n low, synchronous): both registers empty, parse_mode 0, bare-mode
// parse state; a parse_mode write restarts the string in progress.
module css_hex_color_extractor (
    input  logic i_clk,
    input  logic i_rst_n,
    cssx_in_if.sink    i_byte,
    cssx_out_if.source o_color,
    input  logic i_cfg_wr_en,
    input  logic i_cfg_wr_data
);

    logic              r_in_vld;
    logic [7:0]        r_ch;
    logic              r_last;
    logic              r_out_vld;
    cssx_pkg::t_result r_res;

    logic              w_adv;
    cssx_pkg::t_result w_res;

    assign w_adv        = r_in_vld && (!r_last || !r_out_vld || o_color.ready);
    assign i_byte.ready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_byte.ready) begin
                r_in_vld <= i_byte.valid;
            end
            if (w_adv && r_last) begin
                r_out_vld <= 1'b1;
            end else if (o_color.ready) begin
                r_out_vld <= 1'b0;
            end
        end
        if (i_byte.ready && i_byte.valid) begin
            r_ch   <= i_byte.ch;
            r_last <= i_byte.last;
        end
        if (w_adv && r_last) begin
            r_res <= w_res;
        end
    end

    cssx_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_adv),
        .i_ch          (r_ch),
        .i_last        (r_last),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_res         (w_res)
    );

    assign o_color.valid       = r_out_vld;
    assign o_color.color_found = r_res.color_found;
    assign o_color.red         = r_res.red;
    assign o_color.green       = r_res.green;
    assign o_color.blue        = r_res.blue;
    assign o_color.alpha       = r_res.alpha;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_color.ready && r_in_vld && r_last) |-> !w_adv)
        else $error("pending result overwritten");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_byte.valid && i_byte.ready) |=> r_in_vld)
        else $error("accepted byte lost");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(w_adv && r_last))
        else $error("result without a last byte");

    a_zero_when_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_res.color_found) |->
        (r_res.red == 8'h00 && r_res.green == 8'h00 &&
         r_res.blue == 8'h00 && r_res.alpha == 8'h00))
        else $error("color not cleared when none found");

endmodule
